// ----- design/srt_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Stream rank tracker package
// Shared constants and types for the rank tracker core and its cells.
// ----------------------------------------------------------------------------
package srt_pkg;

   // Store size and derived widths.
   localparam int Capacity    = 64;
   localparam int ValueWidth  = 32;
   localparam int CountWidth  = $clog2(Capacity + 1);
   localparam int RankWidth   = 7;
   localparam int StatusWidth = 2;

   // Command codes.
   localparam logic CmdInsert = 1'b0;
   localparam logic CmdQuery  = 1'b1;

   // Status codes.
   localparam logic [StatusWidth-1:0] StatusOk    = 2'd0;
   localparam logic [StatusWidth-1:0] StatusEmpty = 2'd1;
   localparam logic [StatusWidth-1:0] StatusFull  = 2'd2;

   // Query payload that walks down the chain of cells.
   typedef struct packed {
      logic signed [ValueWidth-1:0] value;
      logic [CountWidth-1:0]        remaining;
      logic [CountWidth-1:0]        rank;
   } query_type;

   // Query token: payload plus its valid flag.
   typedef struct packed {
      logic      valid;
      query_type query;
   } token_type;

endpackage
`default_nettype wire

// ----- design/srt_cell.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Stream rank tracker cell
// Holds one stored value, shifts it onward on an insert, and adds its own
// comparison to a passing query token before handing the token on.
// ----------------------------------------------------------------------------
module srt_cell (
   input  wire logic                                 clock,
   input  wire logic                                 reset,
   input  wire logic                                 shift_en,
   input  wire logic signed [srt_pkg::ValueWidth-1:0] shift_value_in,
   output logic signed [srt_pkg::ValueWidth-1:0]      shift_value_out,
   input  wire srt_pkg::token_type                   token_in,
   output srt_pkg::token_type                        token_out
);

   logic signed [srt_pkg::ValueWidth-1:0] stored_ff;
   logic                                  valid_ff;
   srt_pkg::query_type                    query_ff;
   srt_pkg::query_type                    query_in;
   logic                                  occupied;
   logic                                  counts;

   // Widens a single flag to the count width.
   function automatic logic [srt_pkg::CountWidth-1:0] CountWidthOne(input logic flag);
      return srt_pkg::CountWidth'(flag);
   endfunction

   // The stored value moves one place down the chain on every insert into a store with room.
   always_ff @(posedge clock) begin
      if (shift_en) begin
         stored_ff <= shift_value_in;
      end
   end

   assign shift_value_out = stored_ff;

   // A cell holds a live entry while the token still has entries to visit.
   assign occupied = (token_in.query.remaining != '0);
   assign counts   = occupied && (stored_ff < $signed(token_in.query.value));

   always_comb begin
      query_in           = token_in.query;
      query_in.remaining = token_in.query.remaining - CountWidthOne(occupied);
      query_in.rank      = token_in.query.rank + CountWidthOne(counts);
   end

   // Token valid flag is control state; the payload needs no reset.
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= token_in.valid;
      end
   end

   always_ff @(posedge clock) begin
      query_ff <= query_in;
   end

   assign token_out.valid = valid_ff;
   assign token_out.query = query_ff;

endmodule
`default_nettype wire

// ----- design/stream_rank_tracker_core.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Stream rank tracker core
// Keeps a multiset of signed values in a chain of cells and reports, for a
// query, how many stored values are strictly less than the queried value.
// ----------------------------------------------------------------------------
//
//  Channel   Ports                                 Transfer when
//  request   start, busy, req_command, req_value   start high and busy low
//  response  rsp_strobe, rsp_rank, rsp_status      rsp_strobe high
//
// An insert, a query on an empty store and a dropped insert give their
// response in the cycle after the transfer, and busy stays low, so such items
// may follow each other in every cycle. A query on a non-empty store walks
// the chain of Capacity cells, one cell a cycle: its response appears
// once the token has left the last cell and passed the response register, and busy is high until then.
// Reset empties the store at once. The receiver cannot stall responses.
//
module stream_rank_tracker_core (
   input  wire logic                                 clock,
   input  wire logic                                 reset,
   input  wire logic                                 start,
   output logic                                      busy,
   input  wire logic                                 req_command,
   input  wire logic signed [srt_pkg::ValueWidth-1:0] req_value,
   output logic                                      rsp_strobe,
   output logic [srt_pkg::RankWidth-1:0]             rsp_rank,
   output logic [srt_pkg::StatusWidth-1:0]           rsp_status
);

   logic [srt_pkg::CountWidth-1:0]        count_ff;
   logic [srt_pkg::CountWidth-1:0]        count_in;
   logic                                  busy_ff;
   logic                                  busy_in;
   logic                                  strobe_ff;
   logic                                  strobe_in;
   logic [srt_pkg::RankWidth-1:0]         rank_ff;
   logic [srt_pkg::RankWidth-1:0]         rank_in;
   logic [srt_pkg::StatusWidth-1:0]       status_ff;
   logic [srt_pkg::StatusWidth-1:0]       status_in;
   logic                                  accept;
   logic                                  is_full;
   logic                                  shift_en;
   logic                                  launch;
   srt_pkg::token_type                    token_chain [srt_pkg::Capacity+1];
   logic signed [srt_pkg::ValueWidth-1:0] value_chain [srt_pkg::Capacity+1];
   srt_pkg::token_type                    last_token;

   assign accept  = start && !busy_ff;
   assign is_full = (count_ff == srt_pkg::CountWidth'(srt_pkg::Capacity));

   // An insert into a store with room shifts every value down one cell.
   assign shift_en = accept && (req_command == srt_pkg::CmdInsert) && !is_full;

   // A query on a non-empty store launches a token into the first cell.
   assign launch = accept && (req_command == srt_pkg::CmdQuery) && (count_ff != '0);

   assign value_chain[0]                 = req_value;
   assign token_chain[0].valid           = launch;
   assign token_chain[0].query.value     = req_value;
   assign token_chain[0].query.remaining = count_ff;
   assign token_chain[0].query.rank      = '0;

   // Chain of cells.
   for (genvar i = 0; i < srt_pkg::Capacity; i++) begin : g_cell
      srt_cell u_cell (
         .clock           (clock),
         .reset           (reset),
         .shift_en        (shift_en),
         .shift_value_in  (value_chain[i]),
         .shift_value_out (value_chain[i+1]),
         .token_in        (token_chain[i]),
         .token_out       (token_chain[i+1])
      );
   end

   assign last_token = token_chain[srt_pkg::Capacity];

   // Fill count, busy flag and response selection.
   always_comb begin
      count_in  = count_ff;
      busy_in   = busy_ff;
      strobe_in = 1'b0;
      rank_in   = '0;
      status_in = srt_pkg::StatusOk;
      if (last_token.valid) begin
         busy_in   = 1'b0;
         strobe_in = 1'b1;
         rank_in   = srt_pkg::RankWidth'(last_token.query.rank);
      end else if (accept) begin
         strobe_in = !launch;
         busy_in   = launch;
         case (req_command)
            srt_pkg::CmdInsert: begin
               if (is_full) begin
                  status_in = srt_pkg::StatusFull;
               end else begin
                  count_in = count_ff + srt_pkg::CountWidth'(1);
               end
            end
            srt_pkg::CmdQuery: begin
               if (count_ff == '0) begin
                  status_in = srt_pkg::StatusEmpty;
               end
            end
            default: begin
               status_in = srt_pkg::StatusOk;
            end
         endcase
      end
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff  <= '0;
         busy_ff   <= 1'b0;
         strobe_ff <= 1'b0;
      end else begin
         count_ff  <= count_in;
         busy_ff   <= busy_in;
         strobe_ff <= strobe_in;
      end
   end

   // Response payload registers.
   always_ff @(posedge clock) begin
      rank_ff   <= rank_in;
      status_ff <= status_in;
   end

   assign busy       = busy_ff;
   assign rsp_strobe = strobe_ff;
   assign rsp_rank   = rank_ff;
   assign rsp_status = status_ff;

endmodule
`default_nettype wire

// ----- design/srt_checker.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Stream rank tracker checker
// Watches the ports of the core and checks how responses follow transfers.
// ----------------------------------------------------------------------------
module srt_checker (
   input wire logic                                 clock,
   input wire logic                                 reset,
   input wire logic                                 start,
   input wire logic                                 busy,
   input wire logic                                 req_command,
   input wire logic signed [srt_pkg::ValueWidth-1:0] req_value,
   input wire logic                                 rsp_strobe,
   input wire logic [srt_pkg::RankWidth-1:0]        rsp_rank,
   input wire logic [srt_pkg::StatusWidth-1:0]      rsp_status
);

   // An insert transfer is answered in the next cycle with a zero rank.
   a_insert_response: assert property (@(posedge clock) disable iff (reset)
      start && !busy && (req_command == srt_pkg::CmdInsert)
      |=> rsp_strobe && (rsp_rank == '0)
          && ((rsp_status == srt_pkg::StatusOk) || (rsp_status == srt_pkg::StatusFull)))
      else $error("insert transfer not answered correctly");

   // A query transfer either answers at once or starts a chain walk.
   a_query_progress: assert property (@(posedge clock) disable iff (reset)
      start && !busy && (req_command == srt_pkg::CmdQuery) |=> rsp_strobe || busy)
      else $error("query transfer neither answered nor in progress");

   // The end of a chain walk always delivers its response.
   a_walk_done: assert property (@(posedge clock) disable iff (reset)
      $fell(busy) && !$past(reset) |-> rsp_strobe && (rsp_status == srt_pkg::StatusOk))
      else $error("chain walk ended without a response");

   // An empty-store answer carries a zero rank.
   a_empty_rank: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe && (rsp_status == srt_pkg::StatusEmpty) |-> (rsp_rank == '0))
      else $error("empty-store response with non-zero rank");

   // Every request transfer carries a known command and value.
   a_known_request: assert property (@(posedge clock) disable iff (reset)
      start && !busy |-> !$isunknown({req_command, req_value}))
      else $error("request transfer with unknown payload");

endmodule

bind stream_rank_tracker_core srt_checker u_srt_checker (.*);
`default_nettype wire
